[sv/prc_pkg.sv]
// Package for the point range crop and rigid transform block.
// Holds register indexes, shared constants, the matrix sequencer states and
// the structs passed between modules. Depends on nothing.
`default_nettype none

package prc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE   = 3'd7;

    localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;
    localparam logic [31:0]        RANGE_RESET  = 32'd1310720350;

    localparam int MAT_W = 18;
    localparam logic [MAT_W-1:0] ONE_Q16 = 18'd65536;
    localparam logic [8:0][MAT_W-1:0] IDENTITY_MAT = {
        ONE_Q16, 18'd0, 18'd0,
        18'd0, ONE_Q16, 18'd0,
        18'd0, 18'd0, ONE_Q16
    };

    localparam logic [19:0] MM_SQ_PER_M_SQ = 20'd1000000;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_CHECK,
        M_NUM,
        M_DIV,
        M_STORE
    } mat_state_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        logic [2:0][31:0] shift;
        logic [31:0]      min_sq;
        logic [31:0]      max_sq;
    } xform_cfg_t;

    typedef struct packed {
        logic [8:0][MAT_W-1:0] m;
        logic                  degenerate;
    } rot_t;

endpackage

`default_nettype wire

[sv/prc_cfg_regs.sv]
// Configuration register file for the point range crop block.
// Holds the quaternion, translation and range registers and the squared
// range bounds. Depends on prc_pkg.
`default_nettype none

module prc_cfg_regs
    import prc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output quat_t                      quat,
    output xform_cfg_t                 xcfg
);

    localparam logic [31:0] MIN_SQ_RESET = 32'(RANGE_RESET[15:0]) * 32'(RANGE_RESET[15:0]);
    localparam logic [31:0] MAX_SQ_RESET = 32'(RANGE_RESET[31:16]) * 32'(RANGE_RESET[31:16]);

    quat_t            quat_reg;
    logic [2:0][31:0] shift_reg;
    logic [31:0]      range_reg;
    logic [31:0]      min_sq_reg;
    logic [31:0]      max_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg   <= '{w: QUAT_W_RESET, x: 16'sd0, y: 16'sd0, z: 16'sd0};
            shift_reg  <= '0;
            range_reg  <= RANGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUAT_W:  quat_reg.w   <= cfg_data[15:0];
                REG_QUAT_X:  quat_reg.x   <= cfg_data[15:0];
                REG_QUAT_Y:  quat_reg.y   <= cfg_data[15:0];
                REG_QUAT_Z:  quat_reg.z   <= cfg_data[15:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_data;
                REG_SHIFT_Y: shift_reg[1] <= cfg_data;
                REG_SHIFT_Z: shift_reg[2] <= cfg_data;
                REG_RANGE:   range_reg    <= cfg_data;
                default:     range_reg    <= range_reg;
            endcase
        end
    end

    // The squared bounds follow the range register in the next cycle, well ahead
    // of the compare stage of any word entering after the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sq_reg <= MIN_SQ_RESET;
            max_sq_reg <= MAX_SQ_RESET;
        end
        else
        begin
            min_sq_reg <= 32'(range_reg[15:0]) * 32'(range_reg[15:0]);
            max_sq_reg <= 32'(range_reg[31:16]) * 32'(range_reg[31:16]);
        end
    end

    assign quat        = quat_reg;
    assign xcfg.shift  = shift_reg;
    assign xcfg.min_sq = min_sq_reg;
    assign xcfg.max_sq = max_sq_reg;

endmodule

`default_nettype wire

[sv/prc_matrix_unit.sv]
// Rotation matrix sequencer for the point range crop block.
// Derives the normalized Q2.16 matrix from the quaternion with one shared
// multiplier and a restoring divider. Depends on prc_pkg.
`default_nettype none

module prc_matrix_unit
    import prc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  quat_t      quat,
    output logic       busy,
    output rot_t       rot
);

    localparam int PROD_COUNT = 10;
    localparam int ENTRIES    = 9;
    localparam int DIV_STEPS  = 17;

    localparam logic [3:0] P_WW = 4'd0;
    localparam logic [3:0] P_XX = 4'd1;
    localparam logic [3:0] P_YY = 4'd2;
    localparam logic [3:0] P_ZZ = 4'd3;
    localparam logic [3:0] P_XY = 4'd4;
    localparam logic [3:0] P_WZ = 4'd5;
    localparam logic [3:0] P_XZ = 4'd6;
    localparam logic [3:0] P_WY = 4'd7;
    localparam logic [3:0] P_YZ = 4'd8;
    localparam logic [3:0] P_WX = 4'd9;

    mat_state_t state_reg;
    mat_state_t state_next;

    logic [3:0]               mul_idx_reg;
    logic signed [31:0]       prod_reg [PROD_COUNT];
    logic [32:0]              n2_reg;
    logic [3:0]               ent_reg;
    logic                     neg_reg;
    logic [32:0]              rem_reg;
    logic [DIV_STEPS-1:0]     quo_reg;
    logic [4:0]               step_reg;
    logic [8:0][MAT_W-1:0]    mat_reg;
    logic                     deg_reg;

    logic signed [15:0] op_a;
    logic signed [15:0] op_b;
    logic signed [31:0] mul_out;
    logic [32:0]        n2;
    logic signed [33:0] num;
    logic [32:0]        mag;
    logic [49:0]        dividend;
    logic [33:0]        trial;
    logic [33:0]        diff;
    logic               fits;
    logic [MAT_W-1:0]   quo_ext;

    function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
        ext34 = 34'(v);
    endfunction

    always_comb
    begin
        unique case (mul_idx_reg)
            P_WW:    begin op_a = quat.w; op_b = quat.w; end
            P_XX:    begin op_a = quat.x; op_b = quat.x; end
            P_YY:    begin op_a = quat.y; op_b = quat.y; end
            P_ZZ:    begin op_a = quat.z; op_b = quat.z; end
            P_XY:    begin op_a = quat.x; op_b = quat.y; end
            P_WZ:    begin op_a = quat.w; op_b = quat.z; end
            P_XZ:    begin op_a = quat.x; op_b = quat.z; end
            P_WY:    begin op_a = quat.w; op_b = quat.y; end
            P_YZ:    begin op_a = quat.y; op_b = quat.z; end
            P_WX:    begin op_a = quat.w; op_b = quat.x; end
            default: begin op_a = 16'sd0; op_b = 16'sd0; end
        endcase
    end

    assign mul_out = op_a * op_b;

    assign n2 = 33'(unsigned'(prod_reg[P_WW])) + 33'(unsigned'(prod_reg[P_XX]))
              + 33'(unsigned'(prod_reg[P_YY])) + 33'(unsigned'(prod_reg[P_ZZ]));

    always_comb
    begin
        unique case (ent_reg)
            4'd0: num = ext34(prod_reg[P_WW]) + ext34(prod_reg[P_XX])
                      - ext34(prod_reg[P_YY]) - ext34(prod_reg[P_ZZ]);
            4'd1: num = (ext34(prod_reg[P_XY]) - ext34(prod_reg[P_WZ])) <<< 1;
            4'd2: num = (ext34(prod_reg[P_XZ]) + ext34(prod_reg[P_WY])) <<< 1;
            4'd3: num = (ext34(prod_reg[P_XY]) + ext34(prod_reg[P_WZ])) <<< 1;
            4'd4: num = ext34(prod_reg[P_WW]) - ext34(prod_reg[P_XX])
                      + ext34(prod_reg[P_YY]) - ext34(prod_reg[P_ZZ]);
            4'd5: num = (ext34(prod_reg[P_YZ]) - ext34(prod_reg[P_WX])) <<< 1;
            4'd6: num = (ext34(prod_reg[P_XZ]) - ext34(prod_reg[P_WY])) <<< 1;
            4'd7: num = (ext34(prod_reg[P_YZ]) + ext34(prod_reg[P_WX])) <<< 1;
            4'd8: num = ext34(prod_reg[P_WW]) - ext34(prod_reg[P_XX])
                      - ext34(prod_reg[P_YY]) + ext34(prod_reg[P_ZZ]);
            default: num = 34'sd0;
        endcase
    end

    assign mag      = num[33] ? 33'(-num) : num[32:0];
    assign dividend = {1'b0, mag, 16'd0} + 50'(n2_reg[32:1]);
    assign trial    = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign diff     = trial - {1'b0, n2_reg};
    assign fits     = trial >= {1'b0, n2_reg};
    assign quo_ext  = {1'b0, quo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:  state_next = M_IDLE;
            M_MUL:
            begin
                if (mul_idx_reg == 4'(PROD_COUNT - 1))
                begin
                    state_next = M_CHECK;
                end
            end
            M_CHECK: state_next = (n2 == '0) ? M_IDLE : M_NUM;
            M_NUM:   state_next = M_DIV;
            M_DIV:
            begin
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = M_STORE;
                end
            end
            M_STORE: state_next = (ent_reg == 4'(ENTRIES - 1)) ? M_IDLE : M_NUM;
            default: state_next = M_IDLE;
        endcase
        if (start)
        begin
            state_next = M_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_idx_reg <= '0;
            ent_reg     <= '0;
            step_reg    <= '0;
            mat_reg     <= IDENTITY_MAT;
            deg_reg     <= 1'b0;
        end
        else if (start)
        begin
            mul_idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE: ;
                M_MUL:
                begin
                    prod_reg[mul_idx_reg] <= mul_out;
                    mul_idx_reg <= mul_idx_reg + 4'd1;
                end
                M_CHECK:
                begin
                    n2_reg  <= n2;
                    ent_reg <= '0;
                    if (n2 == '0)
                    begin
                        mat_reg <= IDENTITY_MAT;
                        deg_reg <= 1'b1;
                    end
                    else
                    begin
                        deg_reg <= 1'b0;
                    end
                end
                M_NUM:
                begin
                    neg_reg  <= num[33];
                    rem_reg  <= dividend[49:DIV_STEPS];
                    quo_reg  <= dividend[DIV_STEPS-1:0];
                    step_reg <= '0;
                end
                M_DIV:
                begin
                    rem_reg  <= fits ? diff[32:0] : trial[32:0];
                    quo_reg  <= {quo_reg[DIV_STEPS-2:0], fits};
                    step_reg <= step_reg + 5'd1;
                end
                M_STORE:
                begin
                    mat_reg[ent_reg] <= neg_reg ? -quo_ext : quo_ext;
                    ent_reg <= ent_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    assign busy           = state_reg != M_IDLE;
    assign rot.m          = mat_reg;
    assign rot.degenerate = deg_reg;

endmodule

`default_nettype wire

[sv/prc_pipeline.sv]
// Five stage datapath of the point range crop block: input register, squares and
// matrix products, sums, range scaling and rounding, then compare, shift and saturation.
// Depends on prc_pkg.
`default_nettype none

module prc_pipeline
    import prc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               hold,
    input  rot_t                    rot,
    input  xform_cfg_t              xcfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic               not_finite,
    input  wire logic               cloud_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    kept,
    output logic                    last
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept;

    logic signed [31:0] p1_reg [3];
    logic               nf1_reg, end1_reg;

    logic [63:0]        sq2_reg [3];
    logic signed [49:0] prod2_reg [9];
    logic               nf2_reg, end2_reg;

    logic [63:0]        ssum3_reg;
    logic signed [51:0] acc3_reg [3];
    logic               nf3_reg, end3_reg;

    logic [51:0]        hi4_reg, lo4_reg;
    logic signed [36:0] rnd4_reg [3];
    logic               nf4_reg, end4_reg;

    logic signed [31:0] out_reg [3];
    logic               kept_reg, last_reg;

    logic signed [63:0] sq [3];
    logic signed [51:0] acc [3];
    logic signed [51:0] acc_rnd [3];
    logic [83:0]        scaled;
    logic               ge_min, le_max, keep;
    logic signed [37:0] moved [3];

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
        begin
            sat32 = 32'sh7FFFFFFF;
        end
        else if (v < -38'sd2147483648)
        begin
            sat32 = 32'sh80000000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    assign en5      = !v5_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1 || hold;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= accept;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p1_reg[0] <= point_x;
            p1_reg[1] <= point_y;
            p1_reg[2] <= point_z;
            nf1_reg   <= not_finite;
            end1_reg  <= cloud_end;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq[i] = p1_reg[i] * p1_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= unsigned'(sq[i]);
            end
            for (int i = 0; i < 9; i++)
            begin
                prod2_reg[i] <= signed'(rot.m[i]) * p1_reg[i % 3];
            end
            nf2_reg  <= nf1_reg;
            end2_reg <= end1_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 52'(prod2_reg[3*r]) + 52'(prod2_reg[3*r+1]) + 52'(prod2_reg[3*r+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ssum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            for (int r = 0; r < 3; r++)
            begin
                acc3_reg[r] <= acc[r];
            end
            nf3_reg  <= nf2_reg;
            end3_reg <= end2_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_rnd[r] = (acc3_reg[r] + 52'sd32768) >>> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            hi4_reg <= 52'(ssum3_reg[63:32]) * 52'(MM_SQ_PER_M_SQ);
            lo4_reg <= 52'(ssum3_reg[31:0]) * 52'(MM_SQ_PER_M_SQ);
            for (int r = 0; r < 3; r++)
            begin
                rnd4_reg[r] <= acc_rnd[r][36:0];
            end
            nf4_reg  <= nf3_reg;
            end4_reg <= end3_reg;
        end
    end

    assign scaled = {hi4_reg, 32'd0} + 84'(lo4_reg);
    assign ge_min = scaled >= 84'({xcfg.min_sq, 32'd0});
    assign le_max = scaled <= 84'({xcfg.max_sq, 32'd0});
    assign keep   = !rot.degenerate && !nf4_reg && ge_min && le_max;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            moved[r] = 38'(rnd4_reg[r]) + 38'(signed'(xcfg.shift[r]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            for (int r = 0; r < 3; r++)
            begin
                out_reg[r] <= keep ? sat32(moved[r]) : 32'sd0;
            end
            kept_reg <= keep;
            last_reg <= end4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign kept      = kept_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[sv/point_range_crop_rigid_transform.sv]
// Top level of the point range crop and rigid transform block.
// Ties the register file, the matrix sequencer and the datapath together.
// Depends on prc_pkg, prc_cfg_regs, prc_matrix_unit and prc_pipeline.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_stall    point_x, point_y, point_z, not_finite, cloud_end
//   output   out_valid / out_stall  out_x, out_y, out_z, kept, last
//   config   cfg_we                 cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low and passes the input, product,
// sum, scaling and output stages. A quaternion write starts a matrix derivation
// on the shared 16x16 multiplier and restoring divider; the input stalls in the
// write cycle and during the derivation, cut short for an all-zero quaternion.
// Reset loads the identity matrix directly, so no derivation follows reset.
// A stall on the output fills empty stages first, then holds every word.
`default_nettype none

module point_range_crop_rigid_transform
    import prc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [31:0]    point_x,
    input  wire logic signed [31:0]    point_y,
    input  wire logic signed [31:0]    point_z,
    input  wire logic                  not_finite,
    input  wire logic                  cloud_end,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic signed [31:0]         out_z,
    output logic                       kept,
    output logic                       last
);

    quat_t      quat;
    xform_cfg_t xcfg;
    rot_t       rot;
    logic       quat_write;
    logic       busy;

    assign quat_write = cfg_we && (cfg_index == REG_QUAT_W || cfg_index == REG_QUAT_X
                                || cfg_index == REG_QUAT_Y || cfg_index == REG_QUAT_Z);

    prc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .quat      (quat),
        .xcfg      (xcfg)
    );

    prc_matrix_unit u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (quat_write),
        .quat  (quat),
        .busy  (busy),
        .rot   (rot)
    );

    prc_pipeline u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (busy || quat_write),
        .rot        (rot),
        .xcfg       (xcfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .not_finite (not_finite),
        .cloud_end  (cloud_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .kept       (kept),
        .last       (last)
    );

endmodule

`default_nettype wire
